FILE: rtl/psst_pkg.sv
// Shared types, codes and constants of the pose source sequence tracker.
package psst_pkg;

	localparam int SourceSlots = 8;
	localparam int SlotW = (SourceSlots > 1) ? $clog2(SourceSlots) : 1;
	localparam int CntW = $clog2(SourceSlots + 1);

	localparam logic [16:0] Q16One = 17'd65536;

	// Input actions.
	localparam logic [2:0] ACT_OBSERVE = 3'd0;
	localparam logic [2:0] ACT_QUERY   = 3'd1;
	localparam logic [2:0] ACT_REPORT  = 3'd2;
	localparam logic [2:0] ACT_MARK    = 3'd3;
	localparam logic [2:0] ACT_SWEEP   = 3'd4;
	localparam logic [2:0] ACT_CLEAR   = 3'd5;

	// Result kinds.
	localparam logic [1:0] KIND_LOST   = 2'd0;
	localparam logic [1:0] KIND_AGE    = 2'd1;
	localparam logic [1:0] KIND_WEIGHT = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_FRESH   = 2'd0;
	localparam logic [1:0] REG_BLEND   = 2'd1;
	localparam logic [1:0] REG_METRICS = 2'd2;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] entity_id;
		logic [31:0] authority_epoch;
		logic [63:0] sample_seq;
		logic [63:0] time_ns;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [63:0] result_value;
		logic [16:0] weight_q16;
		logic        last_of_run;
	} out_item_t;

	// Divider control between the sequencer and the divider.
	typedef struct packed {
		logic        start;
		logic [57:0] dividend;
		logic [39:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [17:0] quotient;
	} div_rsp_t;

endpackage

FILE: rtl/pose_source_sequence_tracker.sv
// Top level of the pose source sequence tracker: sequencer, table and divider.
// The block handles one transaction at a time. A slot search walks the table
// one slot per cycle. Observe and mark search the table and then decide, and an
// observe that emits a lost count waits in the emit state until it is taken; a
// query searches, decides and computes a weight. An age report, when metrics are
// enabled, walks the slots and waits whenever a result has not yet been taken
// downstream; sweep walks every slot, and clear goes straight to the decide state.
// A weight query in the blend window also waits on the restoring divider.
// in_ready is low while a transaction is in progress; a result sits in an
// output register until taken.
module pose_source_sequence_tracker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  psst_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output psst_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [39:0]         cfg_data
);
	import psst_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_WEIGHT,
		ST_DIV_WAIT,
		ST_REPORT,
		ST_SWEEP,
		ST_EMIT
	} state_t;

	state_t state_q;
	in_item_t item_q;
	logic [39:0] fresh_q;
	logic [39:0] blend_q;
	logic metrics_q;
	logic [SlotW-1:0] idx_q;
	logic hit_q;
	logic [SlotW-1:0] hit_idx_q;
	logic free_q;
	logic [SlotW-1:0] free_idx_q;
	logic [63:0] age_q;
	logic out_valid_q;
	out_item_t out_q;
	logic last_idx;

	logic rd_valid;
	logic rd_keep;
	logic [31:0] rd_entity;
	logic [31:0] rd_epoch;
	logic [63:0] rd_seq;
	logic [63:0] rd_time;
	logic [SlotW-1:0] rd_idx;
	logic wr_key;
	logic wr_sample;
	logic set_keep;
	logic clr_keep;
	logic drop_slot;
	logic clear_all;
	logic [SlotW-1:0] wr_idx;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic key_match;
	logic [63:0] cur_age;
	logic [64:0] blend_age;
	logic [40:0] rem_w;
	logic any_later;
	logic [SourceSlots-1:0] later_valid;

	assign rd_idx = (state_q == ST_DECIDE) ? hit_idx_q : idx_q;
	assign key_match = rd_valid && rd_entity == item_q.entity_id
		&& rd_epoch == item_q.authority_epoch;
	assign last_idx = (idx_q == SlotW'(SourceSlots - 1));
	assign cur_age = (item_q.time_ns >= rd_time) ? item_q.time_ns - rd_time : 64'd0;
	assign blend_age = {1'b0, age_q} - {25'd0, fresh_q};
	assign rem_w = {1'b0, blend_q} - blend_age[40:0];

	psst_table u_table (
		.clk(clk), .arst_n(arst_n), .rd_idx(rd_idx),
		.rd_valid(rd_valid), .rd_keep(rd_keep), .rd_entity(rd_entity),
		.rd_epoch(rd_epoch), .rd_seq(rd_seq), .rd_time(rd_time),
		.wr_key(wr_key), .wr_sample(wr_sample), .set_keep(set_keep),
		.clr_keep(clr_keep),
		.drop_slot(drop_slot), .clear_all(clear_all), .wr_idx(wr_idx),
		.wr_entity(item_q.entity_id), .wr_epoch(item_q.authority_epoch),
		.wr_seq(item_q.sample_seq), .wr_time(item_q.time_ns)
	);

	psst_divider u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// Table write strobes issued by the sequencer.
	always_comb begin
		wr_key = 1'b0;
		wr_sample = 1'b0;
		set_keep = 1'b0;
		clr_keep = 1'b0;
		drop_slot = 1'b0;
		clear_all = 1'b0;
		wr_idx = hit_idx_q;
		if (state_q == ST_DECIDE) begin
			case (item_q.action)
				ACT_OBSERVE: begin
					if (hit_q) begin
						wr_sample = item_q.sample_seq > rd_seq;
					end else if (free_q) begin
						wr_idx = free_idx_q;
						wr_key = 1'b1;
						wr_sample = 1'b1;
					end
				end
				ACT_MARK: set_keep = hit_q;
				ACT_CLEAR: clear_all = 1'b1;
				default: ;
			endcase
		end else if (state_q == ST_SWEEP) begin
			// Unmarked slots are freed, and every keep mark is cleared.
			wr_idx = idx_q;
			drop_slot = !rd_keep;
			clr_keep = 1'b1;
		end
	end

	// Divider request: 65536 * rem + blend / 2, divided by blend.
	always_comb begin
		div_req.start = (state_q == ST_WEIGHT) && hit_q && !(age_q <= {24'd0, fresh_q})
			&& blend_q != 40'd0 && blend_age < {25'd0, blend_q};
		div_req.dividend = {1'b0, rem_w[40:0], 16'd0} + {18'd0, 1'b0, blend_q[39:1]};
		div_req.divisor = blend_q;
	end

	// Any valid slot after idx_q, to flag the last age result.
	always_comb begin
		for (int k = 0; k < SourceSlots; k++) begin
			later_valid[k] = (SlotW'(k) > idx_q) && u_table.valid_q[k];
		end
		any_later = |later_valid;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fresh_q <= 40'd100000000;
			blend_q <= 40'd200000000;
			metrics_q <= 1'b1;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRESH: fresh_q <= cfg_data;
					REG_BLEND: blend_q <= cfg_data;
					REG_METRICS: metrics_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && state_q != ST_REPORT) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						idx_q <= '0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						case (in_data.action)
							ACT_OBSERVE, ACT_QUERY, ACT_MARK: state_q <= ST_SEARCH;
							ACT_REPORT: state_q <= metrics_q ? ST_REPORT : ST_IDLE;
							ACT_SWEEP: state_q <= ST_SWEEP;
							ACT_CLEAR: state_q <= ST_DECIDE;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SEARCH: begin
					if (key_match && !hit_q) begin
						hit_q <= 1'b1;
						hit_idx_q <= idx_q;
					end
					if (!rd_valid && !free_q) begin
						free_q <= 1'b1;
						free_idx_q <= idx_q;
					end
					idx_q <= idx_q + SlotW'(1);
					if (last_idx) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= ST_IDLE;
					if (item_q.action == ACT_OBSERVE && hit_q && metrics_q
							&& item_q.sample_seq > rd_seq
							&& item_q.sample_seq > rd_seq + 64'd1) begin
						out_q.result_kind <= KIND_LOST;
						out_q.result_value <= item_q.sample_seq - rd_seq - 64'd1;
						out_q.weight_q16 <= '0;
						out_q.last_of_run <= 1'b1;
						out_valid_q <= 1'b1;
						state_q <= ST_EMIT;
					end else if (item_q.action == ACT_QUERY) begin
						age_q <= cur_age;
						state_q <= ST_WEIGHT;
					end
				end
				ST_WEIGHT: begin
					out_q.result_kind <= KIND_WEIGHT;
					out_q.result_value <= '0;
					out_q.last_of_run <= 1'b1;
					if (div_req.start) begin
						state_q <= ST_DIV_WAIT;
					end else begin
						out_q.weight_q16 <= (hit_q && age_q <= {24'd0, fresh_q})
							? Q16One : 17'd0;
						out_valid_q <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						out_q.weight_q16 <= div_rsp.quotient[16:0];
						out_valid_q <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_REPORT: begin
					// The previous age result is gone or leaves now; offer the next one.
					if (!out_valid_q || out_ready) begin
						out_valid_q <= rd_valid;
						if (rd_valid) begin
							out_q.result_kind <= KIND_AGE;
							out_q.result_value <= cur_age;
							out_q.weight_q16 <= '0;
							out_q.last_of_run <= !any_later;
						end
						idx_q <= idx_q + SlotW'(1);
						if (last_idx) state_q <= rd_valid ? ST_EMIT : ST_IDLE;
					end
				end
				ST_SWEEP: begin
					idx_q <= idx_q + SlotW'(1);
					if (last_idx) state_q <= ST_DECIDE;
				end
				ST_EMIT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// A result is only offered while a transaction is being worked on or finishing.
	a_no_out_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !out_valid_q)
		else $error("result pending while idle");
	// The divider only finishes while the sequencer waits for it.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside its wait state");
	// A weight never exceeds one.
	a_weight_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.weight_q16 <= Q16One))
		else $error("weight above one");
endmodule

FILE: rtl/psst_divider.sv
// Restoring divider, one quotient bit per cycle, for the blend weight.
module psst_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  psst_pkg::div_req_t req,
	output psst_pkg::div_rsp_t rsp
);
	import psst_pkg::*;

	// Quotient fits in 18 bits because rem is below the divisor.
	localparam int QBits = 18;

	logic [57:0] num_q;
	logic [40:0] part_q;
	logic [39:0] den_q;
	logic [17:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [40:0] shifted;
	logic [41:0] diff;

	// One restoring step: bring down the next dividend bit and try to subtract.
	always_comb begin
		shifted = {part_q[39:0], num_q[57]};
		diff = {1'b0, shifted} - {2'b00, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(QBits);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath; the top 40 dividend bits are below the divisor, so they preload.
	always_ff @(posedge clk) begin
		if (req.start) begin
			part_q <= {1'b0, req.dividend[57:18]};
			num_q <= {req.dividend[17:0], 40'd0};
			den_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[56:0], 1'b0};
			if (!diff[41]) begin
				part_q <= diff[40:0];
				quo_q <= {quo_q[16:0], 1'b1};
			end else begin
				part_q <= shifted;
				quo_q <= {quo_q[16:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
endmodule

FILE: rtl/psst_table.sv
// Slot table: keys, sequence numbers, receive times, valid and keep marks.
module psst_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [psst_pkg::SlotW-1:0] rd_idx,
	output logic                       rd_valid,
	output logic                       rd_keep,
	output logic [31:0]                rd_entity,
	output logic [31:0]                rd_epoch,
	output logic [63:0]                rd_seq,
	output logic [63:0]                rd_time,
	input  logic                       wr_key,
	input  logic                       wr_sample,
	input  logic                       set_keep,
	input  logic                       clr_keep,
	input  logic                       drop_slot,
	input  logic                       clear_all,
	input  logic [psst_pkg::SlotW-1:0] wr_idx,
	input  logic [31:0]                wr_entity,
	input  logic [31:0]                wr_epoch,
	input  logic [63:0]                wr_seq,
	input  logic [63:0]                wr_time
);
	import psst_pkg::*;

	logic [SourceSlots-1:0] valid_q;
	logic [SourceSlots-1:0] keep_q;
	logic [31:0] entity_q [SourceSlots];
	logic [31:0] epoch_q [SourceSlots];
	logic [63:0] seq_q [SourceSlots];
	logic [63:0] time_q [SourceSlots];

	// One slot is read at a time, chosen by the sequencer.
	assign rd_valid = valid_q[rd_idx];
	assign rd_keep = keep_q[rd_idx];
	assign rd_entity = entity_q[rd_idx];
	assign rd_epoch = epoch_q[rd_idx];
	assign rd_seq = seq_q[rd_idx];
	assign rd_time = time_q[rd_idx];

	// Valid and keep bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			keep_q <= '0;
		end else if (clear_all) begin
			valid_q <= '0;
			keep_q <= '0;
		end else begin
			if (wr_key) begin
				valid_q[wr_idx] <= 1'b1;
				keep_q[wr_idx] <= 1'b0;
			end
			if (set_keep) keep_q[wr_idx] <= 1'b1;
			if (clr_keep) keep_q[wr_idx] <= 1'b0;
			if (drop_slot) valid_q[wr_idx] <= 1'b0;
		end
	end

	// Slot payload.
	always_ff @(posedge clk) begin
		if (wr_key) begin
			entity_q[wr_idx] <= wr_entity;
			epoch_q[wr_idx] <= wr_epoch;
		end
		if (wr_sample) begin
			seq_q[wr_idx] <= wr_seq;
			time_q[wr_idx] <= wr_time;
		end
	end
endmodule

FILE: bench/tb.sv
// Self-checking testbench of the pose source sequence tracker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import psst_pkg::*;

	localparam int WatchdogLimit = 20000;
	localparam int DrainCycles = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_FRESH;
	logic [39:0] cfg_data = '0;

	pose_source_sequence_tracker uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Shadow copy of the table and the registers.
	logic [39:0] fresh_ns, blend_ns;
	logic metrics_on;
	logic tbl_valid [SourceSlots];
	logic tbl_keep [SourceSlots];
	logic [31:0] tbl_entity [SourceSlots];
	logic [31:0] tbl_epoch [SourceSlots];
	logic [63:0] tbl_seq [SourceSlots];
	logic [63:0] tbl_rx [SourceSlots];

	out_item_t pending_results[$];
	int errors = 0;
	int sent_items = 0;
	int checked_results = 0;
	int idle_pct = 27;
	int quiet_cycles = 0;
	bit timed_out = 0;

	function automatic int find_slot(logic [31:0] ent, logic [31:0] ep);
		for (int i = 0; i < SourceSlots; i++)
			if (tbl_valid[i] && tbl_entity[i] == ent && tbl_epoch[i] == ep)
				return i;
		return -1;
	endfunction

	function automatic logic [63:0] slot_age(int i, logic [63:0] now);
		return (now >= tbl_rx[i]) ? now - tbl_rx[i] : 64'd0;
	endfunction

	function automatic logic [16:0] freshness(int i, logic [63:0] now);
		logic [63:0] age, bage;
		logic [127:0] num;
		if (i < 0)
			return 17'd0;
		age = slot_age(i, now);
		if (age <= {24'd0, fresh_ns})
			return Q16One;
		bage = age - {24'd0, fresh_ns};
		if (blend_ns == 0 || bage >= {24'd0, blend_ns})
			return 17'd0;
		num = ({64'd0, {24'd0, blend_ns} - bage} << 16) + (blend_ns >> 1);
		return 17'(num / blend_ns);
	endfunction

	function automatic out_item_t mk(logic [1:0] k, logic [63:0] v, logic [16:0] w);
		out_item_t r;
		r.result_kind = k;
		r.result_value = v;
		r.weight_q16 = w;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	// Updates the shadow table and queues the results of one transaction.
	task automatic predict_tracker(in_item_t it);
		out_item_t res[$];
		int s;
		case (it.action)
			ACT_OBSERVE: begin
				s = find_slot(it.entity_id, it.authority_epoch);
				if (s >= 0) begin
					if (it.sample_seq <= tbl_seq[s])
						return;
					if (it.sample_seq > tbl_seq[s] + 1 && metrics_on)
						res.push_back(mk(KIND_LOST, it.sample_seq - tbl_seq[s] - 1, 0));
				end else begin
					s = 0;
					while (s < SourceSlots && tbl_valid[s])
						s++;
					if (s >= SourceSlots)
						return;
					tbl_valid[s] = 1;
					tbl_keep[s] = 0;
					tbl_entity[s] = it.entity_id;
					tbl_epoch[s] = it.authority_epoch;
				end
				tbl_seq[s] = it.sample_seq;
				tbl_rx[s] = it.time_ns;
			end
			ACT_QUERY:
				res.push_back(mk(KIND_WEIGHT, 0,
					freshness(find_slot(it.entity_id, it.authority_epoch), it.time_ns)));
			ACT_REPORT:
				if (metrics_on)
					for (int i = 0; i < SourceSlots; i++)
						if (tbl_valid[i])
							res.push_back(mk(KIND_AGE, slot_age(i, it.time_ns), 0));
			ACT_MARK: begin
				s = find_slot(it.entity_id, it.authority_epoch);
				if (s >= 0)
					tbl_keep[s] = 1;
			end
			ACT_SWEEP:
				for (int i = 0; i < SourceSlots; i++) begin
					if (!tbl_keep[i])
						tbl_valid[i] = 0;
					tbl_keep[i] = 0;
				end
			ACT_CLEAR:
				for (int i = 0; i < SourceSlots; i++) begin
					tbl_valid[i] = 0;
					tbl_keep[i] = 0;
				end
			default: ;
		endcase
		if (res.size() > 0)
			res[res.size() - 1].last_of_run = 1'b1;
		foreach (res[k])
			pending_results.push_back(res[k]);
	endtask

	// Sends one transaction, with random idle cycles before it. Valid stays up
	// at return so that the next transaction can follow with no gap.
	task automatic send_item(in_item_t it);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < idle_pct)
				@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_tracker(it);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic send(logic [2:0] a, logic [31:0] e, logic [31:0] ep,
			logic [63:0] sq, logic [63:0] t);
		in_item_t it;
		it.action = a;
		it.entity_id = e;
		it.authority_epoch = ep;
		it.sample_seq = sq;
		it.time_ns = t;
		send_item(it);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() > 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [39:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FRESH: fresh_ns = val;
			REG_BLEND: blend_ns = val;
			REG_METRICS: metrics_on = val[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Result checker and downstream stalls.
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result kind=%0d value=%0d", out_data.result_kind,
					out_data.result_value);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				checked_results++;
				if (out_data.result_kind !== exp_r.result_kind) begin
					$error("result_kind exp %0d got %0d", exp_r.result_kind,
						out_data.result_kind);
					errors++;
				end
				if (out_data.result_value !== exp_r.result_value) begin
					$error("result_value exp %0d got %0d", exp_r.result_value,
						out_data.result_value);
					errors++;
				end
				if (out_data.weight_q16 !== exp_r.weight_q16) begin
					$error("weight_q16 exp %0d got %0d", exp_r.weight_q16,
						out_data.weight_q16);
					errors++;
				end
				if (out_data.last_of_run !== exp_r.last_of_run) begin
					$error("last_of_run exp %0d got %0d", exp_r.last_of_run,
						out_data.last_of_run);
					errors++;
				end
			end
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= idle_pct);

	// Watchdog on cycles with no transaction on either channel and no register write.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit && !timed_out) begin
			timed_out = 1;
			$display("[pose_source_sequence_tracker] ERROR");
			$finish;
		end
	end

	// Directed: sequence tracking, gaps, stale and repeated samples, table full.
	task automatic test_observe();
		send(ACT_OBSERVE, 32'd1, 32'd1, 64'd10, 64'd1000);
		send(ACT_OBSERVE, 32'd1, 32'd1, 64'd11, 64'd1100);
		send(ACT_OBSERVE, 32'd1, 32'd1, 64'd11, 64'd1200);
		send(ACT_OBSERVE, 32'd1, 32'd1, 64'd5, 64'd1200);
		send(ACT_OBSERVE, 32'd1, 32'd1, 64'd20, 64'd1300);
		send(ACT_OBSERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		send(ACT_OBSERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
		// A sample after the largest sequence number is stale.
		send(ACT_OBSERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd3, 64'd0);
		for (int i = 2; i < SourceSlots + 2; i++)
			send(ACT_OBSERVE, i, 32'd0, 64'd1, 64'd500);
		send(ACT_REPORT, 0, 0, 0, 64'd1250);
	endtask

	// Directed: weight at fresh, in blend, past blend, unknown key, time reversal.
	task automatic test_weight();
		send(ACT_QUERY, 32'd1, 32'd1, 0, 64'd1300);
		send(ACT_QUERY, 32'd1, 32'd1, 0, 64'd0);
		send(ACT_QUERY, 32'd1, 32'd1, 0, 64'd1300 + 64'd150000000);
		send(ACT_QUERY, 32'd1, 32'd1, 0, 64'd1300 + 64'd100000001);
		send(ACT_QUERY, 32'd1, 32'd1, 0, 64'd1300 + 64'd300000000);
		send(ACT_QUERY, 32'd77, 32'd1, 0, 64'd1300);
	endtask

	// Directed: marks, sweep and clear.
	task automatic test_retention();
		send(ACT_MARK, 32'd1, 32'd1, 0, 0);
		send(ACT_MARK, 32'd3, 32'd0, 0, 0);
		send(ACT_MARK, 32'd99, 32'd9, 0, 0);
		send(ACT_SWEEP, 0, 0, 0, 0);
		send(ACT_REPORT, 0, 0, 0, 64'd5000);
		send(3'd6, 0, 0, 0, 0);
		send(3'd7, 32'hFFFF_FFFF, 0, 0, 0);
		send(ACT_CLEAR, 0, 0, 0, 0);
		send(ACT_REPORT, 0, 0, 0, 64'd5000);
	endtask

	// Random traffic over a small key set so that lookups hit often.
	task automatic test_random(int count);
		in_item_t it;
		logic [63:0] clock_ns;
		clock_ns = 64'd1000;
		for (int n = 0; n < count; n++) begin
			it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				3'($urandom)};
			clock_ns += 64'($urandom_range(60000000));
			if ($urandom_range(9) != 0) begin
				it.entity_id = $urandom_range(9);
				it.authority_epoch = $urandom_range(1);
				it.sample_seq = 64'($urandom_range(40));
				it.time_ns = clock_ns;
			end
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6: it.action = ACT_OBSERVE;
				7, 8, 9, 10: it.action = ACT_QUERY;
				11, 12: it.action = ACT_REPORT;
				13, 14, 15: it.action = ACT_MARK;
				16: it.action = ACT_SWEEP;
				17: it.action = ($urandom_range(3) == 0) ? ACT_CLEAR : ACT_MARK;
				default: it.action = 3'($urandom_range(7));
			endcase
			send_item(it);
		end
	endtask

	initial begin
		fresh_ns = 40'd100000000;
		blend_ns = 40'd200000000;
		metrics_on = 1'b1;
		for (int i = 0; i < SourceSlots; i++) begin
			tbl_valid[i] = 0;
			tbl_keep[i] = 0;
		end
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_observe();
		test_weight();
		test_retention();
		wait_idle();

		write_reg(REG_FRESH, 40'd0);
		write_reg(REG_BLEND, 40'd1);
		test_random(50);
		wait_idle();

		write_reg(REG_FRESH, 40'hFF_FFFF_FFFF);
		write_reg(REG_BLEND, 40'hFF_FFFF_FFFF);
		write_reg(REG_METRICS, 40'd0);
		test_random(40);
		wait_idle();

		// No idling on either side for this phase.
		idle_pct = 0;
		write_reg(REG_FRESH, 40'd20000000);
		write_reg(REG_BLEND, 40'd90000000);
		write_reg(REG_METRICS, 40'd1);
		test_random(60);
		wait_idle();
		idle_pct = 27;

		write_reg(REG_FRESH, 40'd30000000);
		write_reg(REG_BLEND, 40'd70000001);
		test_random(60);
		wait_idle();

		$display("Covered %0d input transactions and %0d checked results", sent_items,
			checked_results);
		$display("over directed cases and four register settings.");
		if (errors == 0 && pending_results.size() == 0)
			$display("[pose_source_sequence_tracker] OK");
		else
			$display("[pose_source_sequence_tracker] ERROR");
		$finish;
	end
endmodule
